FILE: sv/obm_pkg.sv
`timescale 1ns / 1ps
package obm_pkg;

	localparam logic [1:0] FUNC_MARKET = 2'd0;
	localparam logic [1:0] FUNC_LIMIT  = 2'd1;
	localparam logic [1:0] FUNC_IOC    = 2'd2;
	localparam logic [1:0] FUNC_FOK    = 2'd3;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [2:0] ST_FILLED    = 3'd0;
	localparam logic [2:0] ST_PARTIAL   = 3'd1;
	localparam logic [2:0] ST_NEW       = 3'd2;
	localparam logic [2:0] ST_CANCELLED = 3'd3;
	localparam logic [2:0] ST_REJECTED  = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic        side;
		logic [31:0] px_limit;
		logic [31:0] order_qty;
		logic [31:0] taker_id;
		logic [47:0] order_time;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] maker_id;
		logic [31:0] taker_ref;
		logic [31:0] trade_price;
		logic [31:0] trade_qty;
		logic        aggressor;
		logic [47:0] trade_time;
		logic [2:0]  final_status;
		logic [31:0] left_qty;
		logic        last;
	} out_item_t;

	// one resting order
	typedef struct packed {
		logic [31:0] price;
		logic [31:0] qty;
		logic [31:0] oid;
	} entry_t;

endpackage

FILE: sv/obm_chan_if.sv
`timescale 1ns / 1ps
interface obm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/obm_ram.sv
`timescale 1ns / 1ps
module obm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: sv/order_book_matcher.sv
`timescale 1ns / 1ps
// each trade, each entry checked by fill-or-kill and each entry shifted by the sorted
// insertion takes a read state and a check state
// orders are taken one at a time: a new one is accepted only back in the idle state
// the pace is set by the single read port of each side's book memory; result stalls add to it
// reset: both book counts and head pointers clear, the sequencer idles, no request pending
module order_book_matcher
	import obm_pkg::*;
#(
	parameter int BOOK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	obm_chan_if.sink   orders,
	obm_chan_if.source results
);
	localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CW = $clog2(BOOK_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_FK_RD   = 4'd1;
	localparam logic [3:0] S_FK_CHK  = 4'd2;
	localparam logic [3:0] S_M_RD    = 4'd3;
	localparam logic [3:0] S_M_CHK   = 4'd4;
	localparam logic [3:0] S_DONE    = 4'd5;
	localparam logic [3:0] S_INS_RD  = 4'd6;
	localparam logic [3:0] S_INS_CHK = 4'd7;
	localparam logic [3:0] S_STAT    = 4'd8;

	// logical slot to physical address in a circular book
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] i);
		logic [CW:0] sum;
		sum = {{(CW+1-AW){1'b0}}, hd} + {1'b0, i};
		if (sum >= (CW+1)'(BOOK_DEPTH)) begin
			sum = sum - (CW+1)'(BOOK_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] next_hd(input logic [AW-1:0] hd);
		return (hd == AW'(BOOK_DEPTH - 1)) ? '0 : hd + AW'(1);
	endfunction

	logic [3:0]    state_q;
	in_item_t      ord_q;
	logic [31:0]   rem_q;
	logic [32:0]   avail_q;
	logic [CW-1:0] i_q;
	logic [2:0]    st_q;
	logic [AW-1:0] bhd_q, ahd_q;
	logic [CW-1:0] bcnt_q, acnt_q;
	out_item_t     out_q;
	logic          out_valid_q;

	// opposite side is the bid book for a sell, the ask book for a buy
	logic          is_sell;
	logic [AW-1:0] opp_hd, own_hd;
	logic [CW-1:0] opp_cnt, own_cnt;
	assign is_sell = (ord_q.side == SIDE_SELL);
	assign opp_hd  = is_sell ? bhd_q : ahd_q;
	assign opp_cnt = is_sell ? bcnt_q : acnt_q;
	assign own_hd  = is_sell ? ahd_q : bhd_q;
	assign own_cnt = is_sell ? acnt_q : bcnt_q;

	// book memories, one read and one write per cycle each
	logic          bid_we, ask_we, bid_re, ask_re;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata;
	logic [EW-1:0] bid_rdata, ask_rdata;
	logic          wr_bid, rd_bid;
	logic          wr_en, rd_en;
	entry_t        rd_e;

	obm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_bid_ram (
		.clk(clk), .we(bid_we), .waddr(waddr), .wdata(wdata),
		.re(bid_re), .raddr(raddr), .rdata(bid_rdata)
	);
	obm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_ask_ram (
		.clk(clk), .we(ask_we), .waddr(waddr), .wdata(wdata),
		.re(ask_re), .raddr(raddr), .rdata(ask_rdata)
	);

	assign bid_we = wr_en & wr_bid;
	assign ask_we = wr_en & ~wr_bid;
	assign bid_re = rd_en & rd_bid;
	assign ask_re = rd_en & ~rd_bid;

	// matching reads the opposite book, insertion reads our own
	always_comb begin
		if (state_q == S_INS_CHK) begin
			rd_e = is_sell ? entry_t'(ask_rdata) : entry_t'(bid_rdata);
		end else begin
			rd_e = is_sell ? entry_t'(bid_rdata) : entry_t'(ask_rdata);
		end
	end

	// shared compare/subtract unit
	logic        cross_lim, cross_any, better_eq, take_all;
	logic [31:0] fill_qty;
	assign cross_lim = is_sell ? (rd_e.price >= ord_q.px_limit)
	                           : (rd_e.price <= ord_q.px_limit);
	assign cross_any = (ord_q.func == FUNC_MARKET) | cross_lim;
	assign better_eq = is_sell ? (rd_e.price <= ord_q.px_limit)
	                           : (rd_e.price >= ord_q.px_limit);
	assign take_all  = (rd_e.qty <= rem_q);
	assign fill_qty  = take_all ? rd_e.qty : rem_q;

	logic out_free;
	assign out_free = ~out_valid_q | results.ready;

	// a trade or the status item enters the output register this cycle
	logic out_load;
	assign out_load = out_free & (((state_q == S_M_CHK) & cross_any) | (state_q == S_STAT));

	assign orders.ready  = (state_q == S_IDLE);
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_comb begin
		wr_en  = 1'b0;
		rd_en  = 1'b0;
		wr_bid = ~is_sell;
		rd_bid = is_sell;
		waddr  = phys(own_hd, i_q);
		raddr  = phys(opp_hd, i_q);
		wdata  = '{price: ord_q.px_limit, qty: rem_q, oid: ord_q.taker_id};
		case (state_q)
			S_FK_RD: begin
				rd_en = (avail_q < {1'b0, ord_q.order_qty}) && (i_q != opp_cnt);
			end
			S_M_RD: begin
				rd_en = (rem_q != '0) && (opp_cnt != '0);
				raddr = opp_hd;
			end
			S_M_CHK: begin
				// shrink the head entry in place
				wr_en  = cross_any & out_free;
				wr_bid = is_sell;
				waddr  = opp_hd;
				wdata  = '{price: rd_e.price, qty: rd_e.qty - fill_qty, oid: rd_e.oid};
			end
			S_INS_RD: begin
				rd_bid = ~is_sell;
				raddr  = phys(own_hd, i_q - CW'(1));
				rd_en  = (i_q != '0);
				wr_en  = (i_q == '0);
			end
			S_INS_CHK: begin
				// shift the entry back one slot unless the new one goes here
				wr_en = 1'b1;
				if (!better_eq) begin
					wdata = rd_e;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bhd_q       <= '0;
			ahd_q       <= '0;
			bcnt_q      <= '0;
			acnt_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (orders.valid) begin
						state_q <= (orders.data.func == FUNC_FOK) ? S_FK_RD : S_M_RD;
					end
				end
				S_FK_RD: begin
					if (avail_q >= {1'b0, ord_q.order_qty}) begin
						state_q <= S_M_RD;
					end else if (i_q == opp_cnt) begin
						state_q <= S_STAT;
					end else begin
						state_q <= S_FK_CHK;
					end
				end
				S_FK_CHK: begin
					state_q <= cross_lim ? S_FK_RD : S_STAT;
				end
				S_M_RD: begin
					state_q <= ((rem_q != '0) && (opp_cnt != '0)) ? S_M_CHK : S_DONE;
				end
				S_M_CHK: begin
					if (!cross_any) begin
						state_q <= S_DONE;
					end else if (out_free) begin
						state_q     <= S_M_RD;
						if (take_all) begin
							if (is_sell) begin
								bhd_q  <= next_hd(bhd_q);
								bcnt_q <= bcnt_q - CW'(1);
							end else begin
								ahd_q  <= next_hd(ahd_q);
								acnt_q <= acnt_q - CW'(1);
							end
						end
					end
				end
				S_DONE: begin
					if ((rem_q != '0) && (ord_q.func == FUNC_LIMIT) &&
					    (own_cnt != CW'(BOOK_DEPTH))) begin
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_STAT;
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						state_q <= S_STAT;
						if (is_sell) acnt_q <= acnt_q + CW'(1);
						else         bcnt_q <= bcnt_q + CW'(1);
					end else begin
						state_q <= S_INS_CHK;
					end
				end
				S_INS_CHK: begin
					if (better_eq) begin
						state_q <= S_STAT;
						if (is_sell) acnt_q <= acnt_q + CW'(1);
						else         bcnt_q <= bcnt_q + CW'(1);
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_STAT: begin
					if (out_free) begin
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ord_q   <= orders.data;
				rem_q   <= orders.data.order_qty;
				avail_q <= '0;
				i_q     <= '0;
				st_q    <= ST_CANCELLED;
			end
			S_FK_CHK: begin
				avail_q <= avail_q + {1'b0, rd_e.qty};
				i_q     <= i_q + CW'(1);
			end
			S_M_CHK: begin
				if (cross_any && out_free) begin
					rem_q <= rem_q - fill_qty;
					out_q <= '{kind: KIND_TRADE, maker_id: rd_e.oid, taker_ref: ord_q.taker_id,
					           trade_price: rd_e.price, trade_qty: fill_qty,
					           aggressor: ord_q.side, trade_time: ord_q.order_time,
					           final_status: ST_FILLED, left_qty: '0, last: 1'b0};
				end
			end
			S_DONE: begin
				i_q <= own_cnt;
				if (rem_q == '0) begin
					st_q <= ST_FILLED;
				end else if (ord_q.func == FUNC_LIMIT) begin
					if (own_cnt == CW'(BOOK_DEPTH)) st_q <= ST_REJECTED;
					else st_q <= (rem_q < ord_q.order_qty) ? ST_PARTIAL : ST_NEW;
				end else begin
					st_q <= (rem_q < ord_q.order_qty) ? ST_PARTIAL : ST_CANCELLED;
				end
			end
			S_INS_CHK: begin
				if (!better_eq) begin
					i_q <= i_q - CW'(1);
				end
			end
			S_STAT: begin
				if (out_free) begin
					out_q <= '{kind: KIND_STATUS, maker_id: '0, taker_ref: ord_q.taker_id,
					           trade_price: '0, trade_qty: '0, aggressor: ord_q.side,
					           trade_time: ord_q.order_time, final_status: st_q,
					           left_qty: rem_q, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	// book occupancy never exceeds its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q <= CW'(BOOK_DEPTH)) && (acnt_q <= CW'(BOOK_DEPTH)))
		else $error("book count above depth");

	// an accepted order keeps the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(orders.valid && orders.ready) |=> !orders.ready)
		else $error("ready right after accept");

	// a trade always moves a nonzero quantity and is never the last item
	a_trade_qty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind == KIND_TRADE)) |-> ((out_q.trade_qty != '0) && !out_q.last))
		else $error("bad trade item");

	// the bid book count moves by at most one per cycle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q == $past(bcnt_q)) || (bcnt_q == $past(bcnt_q) + CW'(1)) ||
		(bcnt_q == $past(bcnt_q) - CW'(1)))
		else $error("bid count jumped");
endmodule

FILE: sim/order_book_matcher_test.sv
`timescale 1ns / 1ps
module order_book_matcher_test;
	import obm_pkg::*;

	localparam int DEPTH      = 32;
	localparam int IDLE_LIMIT = 6000;
	localparam int TAIL_WAIT  = 200;

	logic clk;
	logic arst_n;

	obm_chan_if #(.T(in_item_t))  orders_ch ();
	obm_chan_if #(.T(out_item_t)) results_ch ();

	order_book_matcher #(.BOOK_DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.orders  (orders_ch.sink),
		.results (results_ch.source)
	);

	// mirror of the book plus the queue of items still owed by the block
	class book_scoreboard;
		logic [31:0] lvl_price [2][DEPTH];
		logic [31:0] lvl_qty   [2][DEPTH];
		logic [31:0] lvl_id    [2][DEPTH];
		int          lvl_cnt   [2];
		out_item_t   owed [$];
		int          mismatches;
		int          orders_seen;
		int          trades_seen;
		int          status_seen [5];

		function new();
			lvl_cnt[0] = 0;
			lvl_cnt[1] = 0;
			mismatches = 0;
			orders_seen = 0;
			trades_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function out_item_t mk(logic kind, logic [31:0] maker, logic [31:0] taker,
				logic [31:0] price, logic [31:0] qty, logic aggr, logic [47:0] t,
				logic [2:0] st, logic [31:0] left);
			out_item_t o;
			o.kind = kind;
			o.maker_id = maker;
			o.taker_ref = taker;
			o.trade_price = price;
			o.trade_qty = qty;
			o.aggressor = aggr;
			o.trade_time = t;
			o.final_status = st;
			o.left_qty = left;
			o.last = kind;
			return o;
		endfunction

		// append one expected item at the tail of the queue
		function void owe(out_item_t o);
			owed = {owed, o};
		endfunction

		// index 0 holds bids, index 1 asks
		function bit crossing(logic is_sell, logic [31:0] p, logic [31:0] lim);
			return is_sell ? (p >= lim) : (p <= lim);
		endfunction

		function void pop_head(int s);
			for (int i = 1; i < lvl_cnt[s]; i++) begin
				lvl_price[s][i-1] = lvl_price[s][i];
				lvl_qty[s][i-1]   = lvl_qty[s][i];
				lvl_id[s][i-1]    = lvl_id[s][i];
			end
			lvl_cnt[s]--;
		endfunction

		function void rest(int s, logic is_sell, logic [31:0] p, logic [31:0] q,
				logic [31:0] oid);
			int pos;
			pos = 0;
			while (pos < lvl_cnt[s] &&
					(is_sell ? (lvl_price[s][pos] <= p) : (lvl_price[s][pos] >= p)))
				pos++;
			for (int i = lvl_cnt[s]; i > pos; i--) begin
				lvl_price[s][i] = lvl_price[s][i-1];
				lvl_qty[s][i]   = lvl_qty[s][i-1];
				lvl_id[s][i]    = lvl_id[s][i-1];
			end
			lvl_price[s][pos] = p;
			lvl_qty[s][pos]   = q;
			lvl_id[s][pos]    = oid;
			lvl_cnt[s]++;
		endfunction

		// work out every item one accepted request causes
		function void note_order(in_item_t r);
			int          opp;
			int          own;
			bit          any;
			logic [31:0] left;
			logic [31:0] fill;
			logic [63:0] avail;
			logic [2:0]  st;
			opp = r.side ? 0 : 1;
			own = r.side ? 1 : 0;
			any = (r.func == FUNC_MARKET);
			left = r.order_qty;
			orders_seen++;
			if (r.func == FUNC_FOK) begin
				avail = 0;
				for (int i = 0; i < lvl_cnt[opp] && avail < r.order_qty; i++) begin
					if (!crossing(r.side, lvl_price[opp][i], r.px_limit)) break;
					avail += lvl_qty[opp][i];
				end
				if (avail < r.order_qty) begin
					owe(mk(KIND_STATUS, 0, r.taker_id, 0, 0, r.side,
						r.order_time, ST_CANCELLED, r.order_qty));
					return;
				end
			end
			while (left != 0 && lvl_cnt[opp] > 0 &&
					(any || crossing(r.side, lvl_price[opp][0], r.px_limit))) begin
				fill = (left < lvl_qty[opp][0]) ? left : lvl_qty[opp][0];
				owe(mk(KIND_TRADE, lvl_id[opp][0], r.taker_id,
					lvl_price[opp][0], fill, r.side, r.order_time, ST_FILLED, 0));
				left -= fill;
				lvl_qty[opp][0] -= fill;
				if (lvl_qty[opp][0] == 0) pop_head(opp);
			end
			if (left == 0) begin
				st = ST_FILLED;
			end else if (r.func == FUNC_LIMIT) begin
				if (lvl_cnt[own] >= DEPTH) begin
					st = ST_REJECTED;
				end else begin
					rest(own, r.side, r.px_limit, left, r.taker_id);
					st = (left < r.order_qty) ? ST_PARTIAL : ST_NEW;
				end
			end else begin
				st = (left < r.order_qty) ? ST_PARTIAL : ST_CANCELLED;
			end
			owe(mk(KIND_STATUS, 0, r.taker_id, 0, 0, r.side, r.order_time,
				st, left));
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got,
				ref bit bad);
			if (want !== got) begin
				bad = 1;
				if (mismatches < 10)
					$display("mismatch %s: expected %0h got %0h", name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			bit bad;
			bad = 0;
			if (owed.size() == 0) begin
				if (mismatches < 10) $display("unexpected result item %p", got);
				mismatches++;
				return;
			end
			want = owed.pop_front();
			field("kind", want.kind, got.kind, bad);
			field("maker_id", want.maker_id, got.maker_id, bad);
			field("taker_ref", want.taker_ref, got.taker_ref, bad);
			field("trade_price", want.trade_price, got.trade_price, bad);
			field("trade_qty", want.trade_qty, got.trade_qty, bad);
			field("aggressor", want.aggressor, got.aggressor, bad);
			field("trade_time", want.trade_time, got.trade_time, bad);
			field("final_status", want.final_status, got.final_status, bad);
			field("left_qty", want.left_qty, got.left_qty, bad);
			field("last", want.last, got.last, bad);
			if (bad) mismatches++;
			if (want.kind == KIND_TRADE) trades_seen++;
			else if (want.final_status <= ST_REJECTED) status_seen[want.final_status]++;
		endfunction
	endclass

	book_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;
	logic [31:0] next_id;

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		orders_ch.valid = 1'b0;
		orders_ch.data = '0;
		results_ch.ready = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk)
		results_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	// monitors: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n && orders_ch.valid && orders_ch.ready)
			sb.note_order(orders_ch.data);
		if (arst_n && results_ch.valid && results_ch.ready)
			sb.check_result(results_ch.data);
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((orders_ch.valid && orders_ch.ready) || (results_ch.valid && results_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress, %0d items still owed", sb.owed.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// hold one request until accepted, with random idle gaps in front
	task automatic send_order(logic [1:0] func, logic side, logic [31:0] price,
			logic [31:0] qty, logic [31:0] oid, logic [47:0] t);
		in_item_t r;
		r.func = func;
		r.side = side;
		r.px_limit = price;
		r.order_qty = qty;
		r.taker_id = oid;
		r.order_time = t;
		while ($urandom_range(99) < send_idle_pct) begin
			orders_ch.valid <= 1'b0;
			@(posedge clk);
		end
		orders_ch.valid <= 1'b1;
		orders_ch.data <= r;
		@(posedge clk);
		while (!orders_ch.ready) @(posedge clk);
	endtask

	task automatic send_simple(logic [1:0] func, logic side, logic [31:0] price,
			logic [31:0] qty);
		next_id++;
		send_order(func, side, price, qty, next_id, 48'({$urandom, $urandom}));
	endtask

	// sender stops until the block has delivered everything owed
	task automatic drain();
		orders_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
	endtask

	// resting orders on both sides, enough to fill one side
	task automatic build_book();
		for (int i = 0; i < DEPTH + 2; i++)
			send_simple(FUNC_LIMIT, SIDE_BUY, $urandom_range(999, 900), $urandom_range(40, 1));
		for (int i = 0; i < DEPTH / 2; i++)
			send_simple(FUNC_LIMIT, SIDE_SELL, $urandom_range(1100, 1001),
				$urandom_range(40, 1));
	endtask

	// mostly orders around the spread so that they cross or rest, some wild values
	task automatic random_order();
		logic [1:0]  func;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
		int          pick;
		pick = $urandom_range(99);
		side = 1'($urandom_range(1));
		if (pick < 35) func = FUNC_LIMIT;
		else if (pick < 55) func = FUNC_IOC;
		else if (pick < 75) func = FUNC_FOK;
		else if (pick < 88) func = FUNC_MARKET;
		else func = 2'($urandom_range(3));
		if ($urandom_range(19) == 0) price = $urandom;
		else if (func == FUNC_LIMIT && $urandom_range(1))
			price = side ? $urandom_range(1100, 1001) : $urandom_range(999, 900);
		else price = $urandom_range(1100, 900);
		if ($urandom_range(29) == 0) qty = $urandom | 32'h1;
		else qty = $urandom_range(80, 1);
		next_id++;
		send_order(func, side, price, qty, $urandom_range(9) == 0 ? $urandom : next_id,
			48'({$urandom, $urandom}));
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_cycles = 0;
		next_id = 32'd100;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty book, time priority, fill-or-kill both ways, extremes
		send_order(FUNC_MARKET, SIDE_BUY, 0, 5, 1, 48'd1);
		send_order(FUNC_IOC, SIDE_SELL, 100, 5, 2, 48'd2);
		send_order(FUNC_FOK, SIDE_BUY, 100, 5, 3, 48'd3);
		send_order(FUNC_LIMIT, SIDE_BUY, 100, 10, 4, 48'd4);
		send_order(FUNC_LIMIT, SIDE_BUY, 100, 5, 5, 48'd5);
		send_order(FUNC_LIMIT, SIDE_BUY, 90, 7, 6, 48'd6);
		send_order(FUNC_LIMIT, SIDE_SELL, 200, 4, 7, 48'd7);
		send_order(FUNC_LIMIT, SIDE_SELL, 210, 6, 8, 48'd8);
		send_order(FUNC_FOK, SIDE_SELL, 95, 20, 9, 48'd9);
		send_order(FUNC_FOK, SIDE_SELL, 100, 12, 10, 48'd10);
		send_order(FUNC_IOC, SIDE_SELL, 90, 100, 11, 48'd11);
		send_order(FUNC_LIMIT, SIDE_SELL, 150, 0, 12, 48'd12);
		send_order(FUNC_MARKET, SIDE_SELL, 0, 3, 13, 48'd13);
		send_order(FUNC_LIMIT, SIDE_BUY, 205, 10, 14, 48'd14);
		send_order(FUNC_MARKET, SIDE_BUY, 32'hFFFF_FFFF, 3, 15, 48'd15);
		send_order(FUNC_LIMIT, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		send_order(FUNC_LIMIT, SIDE_SELL, 0, 32'hFFFF_FFFF, 0, 48'd0);
		send_order(FUNC_FOK, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 18, 48'd18);
		send_order(FUNC_MARKET, SIDE_BUY, 0, 32'hFFFF_FFFF, 19, 48'd19);
		send_order(FUNC_IOC, SIDE_BUY, 32'hFFFF_FFFF, 1, 20, 48'd20);
		drain();

		// three idling profiles, book rebuilt to the full mark each time
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 85 : 0;
			recv_stall_pct = (ph == 0) ? 85 : (ph == 1) ? 13 : 0;
			build_book();
			for (int n = 0; n < 100; n++) random_order();
			drain();
		end
		orders_ch.valid <= 1'b0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("orders %0d, trades %0d; filled %0d partial %0d rested %0d",
			sb.orders_seen, sb.trades_seen, sb.status_seen[ST_FILLED],
			sb.status_seen[ST_PARTIAL], sb.status_seen[ST_NEW]);
		$display("cancelled %0d, rejected on full book %0d, mismatches %0d",
			sb.status_seen[ST_CANCELLED], sb.status_seen[ST_REJECTED], sb.mismatches);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
